// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the block's RTL modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PLMVD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition in a cycle implies a consequence in the next cycle.
`define PLMVD_ASSERT_NEXT(name, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ----- rtl/plmvd_pkg.sv -----
// Shared types, widths and codes for the packed triangular matrix-vector block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package plmvd_pkg;

    // Field widths of the words on the ports.
    localparam int VAL_W      = 32;
    localparam int FRAC_W     = 24;
    localparam int ACT_W      = 2;
    localparam int IDX_W      = 7;
    localparam int ROW_W      = 4;
    localparam int STAGE_W    = 5;
    localparam int ROWC_W     = 4;
    localparam int DERIV_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Default matrix order.
    localparam int DEF_MAX_STAGES = 16;

    // Configuration reset values.
    localparam logic [STAGE_W-1:0] STAGE_COUNT_RST = 5'd16;
    localparam logic [ROWC_W-1:0]  ROW_COUNT_RST   = 4'd15;
    localparam logic [DERIV_W-1:0] DERIV_ENTRY_RST = 7'd127;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_ENTRY = 2'd2;

    // Input word actions.
    typedef enum logic [ACT_W-1:0] {
        ACT_MAT_WR  = 2'd0,
        ACT_VEC_WR  = 2'd1,
        ACT_COMPUTE = 2'd2
    } action_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Per-entry tags that travel down the datapath pipeline.
    typedef struct packed {
        logic             first;
        logic             row_end;
        logic             last;
        logic             hit;
        logic [ROW_W-1:0] row;
    } mac_tag_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic     mat_we;
        logic     vec_we;
        logic     issue;
        mac_tag_t tag;
    } dp_cmd_t;

endpackage

// ----- rtl/packed_lower_triangular_matvec_dual.sv -----
// Top level of the packed lower triangular matrix-vector block with tangent.
// Depends on plmvd_pkg, plmvd_ctrl and plmvd_datapath.
`timescale 1ns / 1ps

// Usage:
//   Input words are taken when start is high and busy is low. Action 0 writes
//   one packed matrix entry, action 1 writes one vector element and its
//   tangent; busy stays low for both, so loads stream at one word per cycle.
//   Action 2 computes the trailing R rows and raises busy if R is not zero.
//   A compute walks the sub-triangle one entry per cycle through the single
//   read port of the matrix memory, so it issues R*(R+1)/2 entries. Each
//   row's word appears once its last entry has passed the read, product,
//   accumulate and output registers, for one cycle, marked by result_valid;
//   last marks the final row. busy falls in the cycle after that final word.
//   With a row count of zero a compute gives no words. Configuration is
//   written through cfg_valid/cfg_ready, ready while idle. The receiver
//   cannot stall: each result word is on the ports for exactly one cycle.
//   Reset restores the configuration defaults and aborts any run; store
//   contents are undefined until written.
module packed_lower_triangular_matvec_dual
    import plmvd_pkg::*;
#(
    parameter int MAX_STAGES = DEF_MAX_STAGES
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [ACT_W-1:0]        action,
    input  logic [IDX_W-1:0]        index,
    input  logic signed [VAL_W-1:0] value,
    input  logic signed [VAL_W-1:0] tangent,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output logic                    result_valid,
    output logic [ROW_W-1:0]        row,
    output logic signed [VAL_W-1:0] out_value,
    output logic signed [VAL_W-1:0] out_tangent,
    output logic                    last
);

    localparam int MAT_DEPTH = MAX_STAGES * (MAX_STAGES - 1) / 2;
    localparam int MAW       = $clog2(MAT_DEPTH > 1 ? MAT_DEPTH : 2);
    localparam int VAW       = $clog2(MAX_STAGES);

    dp_cmd_t        cmd;
    logic [MAW-1:0] rd_addr;
    logic [VAW-1:0] vec_addr;
    logic           res_last;

    // Sequencer and configuration.
    plmvd_ctrl #(
        .MAX_STAGES (MAX_STAGES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .index     (index),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_last  (res_last),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .vec_addr  (vec_addr)
    );

    // Stores and multiply-accumulate pipeline.
    plmvd_datapath #(
        .MAX_STAGES (MAX_STAGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .vec_addr     (vec_addr),
        .index        (index),
        .value        (value),
        .tangent      (tangent),
        .result_valid (result_valid),
        .row          (row),
        .out_value    (out_value),
        .out_tangent  (out_tangent),
        .last         (last),
        .res_last     (res_last)
    );

endmodule

// ----- rtl/plmvd_ctrl.sv -----
// Controller: configuration registers, input decode and the sequencer that
// walks the packed sub-triangle. Depends on plmvd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plmvd_ctrl
    import plmvd_pkg::*;
#(
    parameter int MAX_STAGES = DEF_MAX_STAGES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ACT_W-1:0]      action,
    input  logic [IDX_W-1:0]      index,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  res_last,
    output logic                  busy,
    output logic                  cfg_ready,
    output dp_cmd_t               cmd,
    output logic [$clog2(MAX_STAGES*(MAX_STAGES-1)/2 > 1 ?
                         MAX_STAGES*(MAX_STAGES-1)/2 : 2)-1:0] rd_addr,
    output logic [$clog2(MAX_STAGES)-1:0] vec_addr
);

    localparam int MAT_DEPTH = MAX_STAGES * (MAX_STAGES - 1) / 2;
    localparam int MAW       = $clog2(MAT_DEPTH > 1 ? MAT_DEPTH : 2);
    localparam int VAW       = $clog2(MAX_STAGES);
    localparam int SCW       = $clog2(MAX_STAGES + 1);
    localparam int EW        = (SCW > STAGE_W) ? SCW : STAGE_W;
    localparam int TW        = 2 * VAW + 1;
    localparam int DW        = (MAW > DERIV_W) ? MAW : DERIV_W;
    localparam int MXW_R     = $clog2(MAT_DEPTH + 1);
    localparam int MXW       = (MXW_R > IDX_W) ? MXW_R : IDX_W;
    localparam int VXW_R     = $clog2(MAX_STAGES + 1);
    localparam int VXW       = (VXW_R > IDX_W) ? VXW_R : IDX_W;

    state_t               state_reg, state_next;
    logic [VAW-1:0]       i_reg, i_next;
    logic [VAW-1:0]       j_reg, j_next;
    logic [VAW-1:0]       rows_reg, rows_next;
    logic [VAW-1:0]       skp_reg, skp_next;
    logic [MAW-1:0]       addr_reg, addr_next;
    logic [STAGE_W-1:0]   stage_count_reg;
    logic [ROWC_W-1:0]    row_count_reg;
    logic [DERIV_W-1:0]   deriv_entry_reg;

    logic                 accept;
    logic [EW-1:0]        sc_raw, sc_c, sc_m1, rc_raw, rows_c, skp_c;
    logic [TW-1:0]        skp_t, tri_t;
    logic [MAW-1:0]       base_c;
    logic                 mat_in_range, vec_in_range;
    logic                 row_done, run_last;

    // Input word handshake and range checks for store writes.
    assign accept       = start && (state_reg == ST_IDLE);
    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign mat_in_range = (MXW'(index) < MXW'(MAT_DEPTH));
    assign vec_in_range = (VXW'(index) < VXW'(MAX_STAGES));

    // Clamp the order and row count, then find the first packed index.
    always_comb
    begin
        sc_raw = EW'(stage_count_reg);
        if (sc_raw < EW'(2))
            sc_c = EW'(2);
        else if (sc_raw > EW'(MAX_STAGES))
            sc_c = EW'(MAX_STAGES);
        else
            sc_c = sc_raw;
        sc_m1  = sc_c - EW'(1);
        rc_raw = EW'(row_count_reg);
        rows_c = (rc_raw > sc_m1) ? sc_m1 : rc_raw;
        skp_c  = sc_c - rows_c;
        skp_t  = TW'(skp_c);
        tri_t  = (skp_t * (skp_t + TW'(1))) >> 1;
        base_c = MAW'(tri_t - TW'(1));
    end

    assign row_done = (j_reg == i_reg);
    assign run_last = (i_reg == rows_reg - VAW'(1));

    // Command word to the datapath.
    always_comb
    begin
        cmd.mat_we      = accept && (action == ACT_MAT_WR) && mat_in_range;
        cmd.vec_we      = accept && (action == ACT_VEC_WR) && vec_in_range;
        cmd.issue       = (state_reg == ST_RUN);
        cmd.tag.first   = (j_reg == '0);
        cmd.tag.row_end = row_done;
        cmd.tag.last    = run_last;
        cmd.tag.hit     = (DW'(deriv_entry_reg) == DW'(addr_reg));
        cmd.tag.row     = ROW_W'(i_reg);
    end

    assign rd_addr  = addr_reg;
    assign vec_addr = j_reg;

    // Next state and counters of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        rows_next  = rows_reg;
        skp_next   = skp_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_COMPUTE) && (rows_c != '0))
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    rows_next  = VAW'(rows_c);
                    skp_next   = VAW'(skp_c);
                    addr_next  = base_c;
                end
            end
            ST_RUN:
            begin
                if (row_done)
                begin
                    if (run_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        // The next row starts skp entries past this row's end.
                        i_next    = i_reg + VAW'(1);
                        j_next    = '0;
                        addr_next = addr_reg + MAW'(skp_reg);
                    end
                end
                else
                begin
                    j_next    = j_reg + VAW'(1);
                    addr_next = addr_reg + MAW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (res_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            rows_reg  <= '0;
            skp_reg   <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            rows_reg  <= rows_next;
            skp_reg   <= skp_next;
            addr_reg  <= addr_next;
        end
    end

    // Configuration registers; an unknown index writes nothing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg <= STAGE_COUNT_RST;
            row_count_reg   <= ROW_COUNT_RST;
            deriv_entry_reg <= DERIV_ENTRY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STAGE_COUNT: stage_count_reg <= cfg_data[STAGE_W-1:0];
                CFG_ROW_COUNT:   row_count_reg   <= cfg_data[ROWC_W-1:0];
                CFG_DERIV_ENTRY: deriv_entry_reg <= cfg_data[DERIV_W-1:0];
                default:         ;
            endcase
        end
    end

    // The walk stays inside the lower triangle of computed rows.
    `PLMVD_ASSERT(a_walk_bounds, (state_reg != ST_RUN) || ((j_reg <= i_reg) && (i_reg < rows_reg)), "walk left the triangle")
    // The final result word ends the run in the following cycle.
    `PLMVD_ASSERT_NEXT(a_last_ends_run, res_last, state_reg == ST_IDLE, "run did not end after last row")

endmodule

// ----- rtl/plmvd_datapath.sv -----
// Datapath: matrix, vector and tangent stores, dual multiply-accumulate
// pipeline, rounding and saturation to Q8.24. Depends on plmvd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plmvd_datapath
    import plmvd_pkg::*;
#(
    parameter int MAX_STAGES = DEF_MAX_STAGES
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    input  logic [$clog2(MAX_STAGES*(MAX_STAGES-1)/2 > 1 ?
                         MAX_STAGES*(MAX_STAGES-1)/2 : 2)-1:0] rd_addr,
    input  logic [$clog2(MAX_STAGES)-1:0] vec_addr,
    input  logic [IDX_W-1:0]         index,
    input  logic signed [VAL_W-1:0]  value,
    input  logic signed [VAL_W-1:0]  tangent,
    output logic                     result_valid,
    output logic [ROW_W-1:0]         row,
    output logic signed [VAL_W-1:0]  out_value,
    output logic signed [VAL_W-1:0]  out_tangent,
    output logic                     last,
    output logic                     res_last
);

    localparam int MAT_DEPTH = MAX_STAGES * (MAX_STAGES - 1) / 2;
    localparam int MAW       = $clog2(MAT_DEPTH > 1 ? MAT_DEPTH : 2);
    localparam int VAW       = $clog2(MAX_STAGES);
    localparam int PROD_W    = 2 * VAL_W;
    localparam int DT_W      = VAL_W + FRAC_W;
    localparam int ACC_W     = PROD_W + $clog2(MAX_STAGES) + 1;
    localparam int TOP_B     = FRAC_W + VAL_W - 1;
    localparam logic [ACC_W-1:0] RND =
        {{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic [VAL_W-1:0]         mat_mem [MAT_DEPTH];
    logic [VAL_W-1:0]         vec_mem [MAX_STAGES];
    logic [VAL_W-1:0]         tan_mem [MAX_STAGES];

    logic                     v1_reg, v2_reg, v3_reg;
    mac_tag_t                 t1_reg, t2_reg;
    logic                     l3_reg;
    logic [ROW_W-1:0]         row3_reg;
    logic signed [VAL_W-1:0]  mat_q_reg, vec_q_reg, tan_q_reg;
    logic signed [PROD_W-1:0] pv_reg, pt_reg;
    logic signed [DT_W-1:0]   dt_reg;
    logic [ACC_W-1:0]         accv_reg, acct_reg, accv_next, acct_next;
    logic [ACC_W-1:0]         basev, baset;

    logic                     ov_reg;
    logic [ROW_W-1:0]         orow_reg;
    logic [VAL_W-1:0]         oval_reg, otan_reg;
    logic                     olast_reg;

    // Round already folded into the accumulator start; keep bits 55:24.
    function automatic logic [VAL_W-1:0] sat_q(input logic [ACC_W-1:0] a);
        logic all_ones;
        logic all_zeros;
        all_ones  = &a[ACC_W-1:TOP_B];
        all_zeros = ~|a[ACC_W-1:TOP_B];
        if (all_ones || all_zeros)
            sat_q = a[TOP_B:FRAC_W];
        else
            sat_q = a[ACC_W-1] ? SAT_MIN : SAT_MAX;
    endfunction

    // Store writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (cmd.mat_we)
            mat_mem[MAW'(index)] <= value;
        if (cmd.vec_we)
        begin
            vec_mem[VAW'(index)] <= value;
            tan_mem[VAW'(index)] <= tangent;
        end
        mat_q_reg <= mat_mem[rd_addr];
        vec_q_reg <= vec_mem[vec_addr];
        tan_q_reg <= tan_mem[vec_addr];
    end

    // Products and the derivative term, one register stage.
    always_ff @(posedge clk)
    begin
        t1_reg <= cmd.tag;
        t2_reg <= t1_reg;
        pv_reg <= mat_q_reg * vec_q_reg;
        pt_reg <= mat_q_reg * tan_q_reg;
        dt_reg <= t1_reg.hit ? {vec_q_reg, {FRAC_W{1'b0}}} : '0;
    end

    // Accumulate; a new row starts from the rounding constant.
    always_comb
    begin
        basev     = t2_reg.first ? RND : accv_reg;
        baset     = t2_reg.first ? RND : acct_reg;
        accv_next = basev + {{(ACC_W-PROD_W){pv_reg[PROD_W-1]}}, pv_reg};
        acct_next = baset + {{(ACC_W-PROD_W){pt_reg[PROD_W-1]}}, pt_reg}
                  + {{(ACC_W-DT_W){dt_reg[DT_W-1]}}, dt_reg};
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            accv_reg <= accv_next;
            acct_reg <= acct_next;
            l3_reg   <= t2_reg.last;
            row3_reg <= t2_reg.row;
        end
        if (v3_reg)
        begin
            orow_reg  <= row3_reg;
            oval_reg  <= sat_q(accv_reg);
            otan_reg  <= sat_q(acct_reg);
            olast_reg <= l3_reg;
        end
    end

    // Valid bits of the pipeline and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && t2_reg.row_end;
            ov_reg <= v3_reg;
        end
    end

    assign result_valid = ov_reg;
    assign row          = orow_reg;
    assign out_value    = oval_reg;
    assign out_tangent  = otan_reg;
    assign last         = olast_reg;
    assign res_last     = ov_reg && olast_reg;

    // A result word follows a row's final entry issue via v1, v2, v3 and ov.
    `PLMVD_ASSERT(a_result_origin, !result_valid || $past(cmd.issue && cmd.tag.row_end, 4), "result without a finished row")
    // Rows after the first have two or more entries, so words never abut.
    `PLMVD_ASSERT_NEXT(a_result_gap, result_valid, !result_valid, "back-to-back result words")

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for packed_lower_triangular_matvec_dual: it drives loads, computes
// and register writes, and checks every result word against a predictor kept in the bench.
// Depends on plmvd_pkg and on the block's RTL.
`timescale 1ns / 1ps

module tb;
    import plmvd_pkg::*;

    localparam int MAX_ST = DEF_MAX_STAGES;
    localparam int MAT_ENTRIES = MAX_ST * (MAX_ST - 1) / 2;
    localparam int ACC_W = 80;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEM_TARGET = 260;
    localparam int GAP_PERCENT = 12;
    // Action code outside the enum; the block must ignore it.
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = 80'sh7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -80'sh8000_0000;

    // One expected result word.
    typedef struct {
        logic [ROW_W-1:0]        row;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] tangent;
        logic                    last;
    } row_word_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [ACT_W-1:0]        action;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] tangent;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    result_valid;
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] out_value;
    logic signed [VAL_W-1:0] out_tangent;
    logic                    last;

    // Bench copy of the block's stores and registers.
    logic signed [VAL_W-1:0] mat_mem [MAT_ENTRIES];
    logic signed [VAL_W-1:0] vec_mem [MAX_ST];
    logic signed [VAL_W-1:0] tan_mem [MAX_ST];
    bit                      mat_written [MAT_ENTRIES];
    bit                      vec_written [MAX_ST];
    logic [STAGE_W-1:0]      stage_reg;
    logic [ROWC_W-1:0]       rowc_reg;
    logic [DERIV_W-1:0]      deriv_reg;

    row_word_t pending_rows[$];
    row_word_t head_word;
    int        fail_count = 0;
    int        items_sent = 0;
    int        quiet_cycles = 0;
    bit        gaps_on = 1'b1;

    packed_lower_triangular_matvec_dual dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .index        (index),
        .value        (value),
        .tangent      (tangent),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .row          (row),
        .out_value    (out_value),
        .out_tangent  (out_tangent),
        .last         (last)
    );

    always #1 clk = ~clk;

    // Matrix order after clamping to the legal range.
    function automatic int used_stages();
        int s;
        s = stage_reg;
        if (s < 2)
            s = 2;
        if (s > MAX_ST)
            s = MAX_ST;
        return s;
    endfunction

    function automatic int used_rows();
        int r;
        r = rowc_reg;
        if (r > used_stages() - 1)
            r = used_stages() - 1;
        return r;
    endfunction

    // Packed index of the first entry that row 0 reads.
    function automatic int first_entry();
        int s;
        s = used_stages() - used_rows();
        return s * (s + 1) / 2 - 1;
    endfunction

    // A packed index between the first and the final entry read by a compute, or any index when no rows are computed.
    function automatic int pick_entry();
        int r;
        int b;
        int hi;
        r = used_rows();
        b = first_entry();
        if (r == 0)
            return $urandom_range(MAT_ENTRIES - 1);
        hi = b + (r - 1) * (used_stages() - r) + (r - 1) * (r - 2) / 2 + r - 1;
        return $urandom_range(hi, b);
    endfunction

    // Round half up from Q32.48 to Q8.24, then saturate to 32 bits.
    function automatic logic signed [VAL_W-1:0] to_q8_24(logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] q;
        q = (acc + HALF_LSB) >>> FRAC_W;
        if (q > SAT_MAX)
            q = SAT_MAX;
        else if (q < SAT_MIN)
            q = SAT_MIN;
        return q[VAL_W-1:0];
    endfunction

    // Expected words of one compute under the current registers and stores.
    function automatic void compute_rows();
        int rows;
        int skip;
        int base;
        int d;
        int i;
        int j;
        logic signed [ACC_W-1:0] acc_v;
        logic signed [ACC_W-1:0] acc_t;
        logic signed [ACC_W-1:0] m;
        logic signed [ACC_W-1:0] vx;
        row_word_t w;
        rows = used_rows();
        skip = used_stages() - rows;
        base = first_entry();
        d = deriv_reg;
        for (i = 0; i < rows; i++)
        begin
            acc_v = '0;
            acc_t = '0;
            for (j = 0; j <= i; j++)
            begin
                m = ACC_W'(mat_mem[base + j]);
                acc_v = acc_v + m * vec_mem[j];
                acc_t = acc_t + m * tan_mem[j];
            end
            // The chosen entry adds the vector element that it multiplies.
            if (d >= base && d <= base + i)
            begin
                vx = ACC_W'(vec_mem[d - base]);
                acc_t = acc_t + (vx <<< FRAC_W);
            end
            w.row = i[ROW_W-1:0];
            w.value = to_q8_24(acc_v);
            w.tangent = to_q8_24(acc_t);
            w.last = (i == rows - 1);
            pending_rows.push_back(w);
            base += skip + i;
        end
    endfunction

    // Update the bench state for one accepted input word.
    function automatic void apply_word(logic [ACT_W-1:0] act, int idx,
                                       logic [VAL_W-1:0] val, logic [VAL_W-1:0] tng);
        case (act)
            ACT_MAT_WR:
                if (idx < MAT_ENTRIES)
                begin
                    mat_mem[idx] = val;
                    mat_written[idx] = 1'b1;
                end
            ACT_VEC_WR:
                if (idx < MAX_ST)
                begin
                    vec_mem[idx] = val;
                    tan_mem[idx] = tng;
                    vec_written[idx] = 1'b1;
                end
            ACT_COMPUTE:
                compute_rows();
            default:
                ;
        endcase
    endfunction

    // Random Q8.24 value: extremes, full range, or small magnitudes.
    function automatic logic [VAL_W-1:0] pick_q();
        logic [25:0] r;
        r = 26'($urandom);
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return {{6{r[25]}}, r};
        endcase
    endfunction

    // Send one input word; start is left high so the next word can follow at once.
    task automatic send_word(logic [ACT_W-1:0] act, int idx,
                             logic [VAL_W-1:0] val, logic [VAL_W-1:0] tng);
        if (gaps_on && $urandom_range(99) < GAP_PERCENT)
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        index <= idx[IDX_W-1:0];
        value <= val;
        tangent <= tng;
        do @(posedge clk); while (busy);
        apply_word(act, idx, val, tng);
        items_sent++;
    endtask

    // Let the block finish all work before registers change or the run ends.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // One register write; cfg_valid is left high for a following write.
    task automatic write_register(logic [CFG_IDX_W-1:0] ridx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= ridx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (ridx)
            CFG_STAGE_COUNT: stage_reg = data[STAGE_W-1:0];
            CFG_ROW_COUNT:   rowc_reg = data[ROWC_W-1:0];
            CFG_DERIV_ENTRY: deriv_reg = data[DERIV_W-1:0];
            default:         ;
        endcase
    endtask

    // Write all three registers; unused upper data bits are random.
    // A negative entry aims the derivative between the first and final entries that the compute reads.
    task automatic configure(int stages, int rows, int entry);
        wait_idle();
        write_register(CFG_STAGE_COUNT, {3'($urandom), 5'(stages)});
        write_register(CFG_ROW_COUNT, {4'($urandom), 4'(rows)});
        if (entry < 0)
            entry = pick_entry();
        write_register(CFG_DERIV_ENTRY, {1'($urandom), 7'(entry)});
        cfg_valid <= 1'b0;
    endtask

    // Load every operand that the next compute reads but that was never written,
    // then send the compute.
    task automatic run_compute();
        int rows;
        int base;
        int i;
        int j;
        rows = used_rows();
        base = first_entry();
        for (i = 0; i < rows; i++)
        begin
            for (j = 0; j <= i; j++)
                if (!mat_written[base + j])
                    send_word(ACT_MAT_WR, base + j, pick_q(), $urandom);
            base += used_stages() - rows + i;
        end
        for (j = 0; j < rows; j++)
            if (!vec_written[j])
                send_word(ACT_VEC_WR, j, pick_q(), pick_q());
        send_word(ACT_COMPUTE, $urandom_range(127), $urandom, $urandom);
    endtask

    // Smallest matrix: one product, driven to both saturation limits,
    // with the derivative entry on that product.
    task automatic test_single_entry();
        configure(2, 1, 0);
        send_word(ACT_MAT_WR, 0, 32'h7FFF_FFFF, 32'h0);
        send_word(ACT_VEC_WR, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(ACT_COMPUTE, 0, 32'h0, 32'h0);
        send_word(ACT_MAT_WR, 0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(ACT_VEC_WR, 0, 32'h8000_0000, 32'h8000_0000);
        send_word(ACT_COMPUTE, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Products of exactly half an output step round up, on both signs.
    task automatic test_rounding();
        configure(2, 1, 127);
        send_word(ACT_MAT_WR, 0, 32'h0000_0001, 32'h0);
        send_word(ACT_VEC_WR, 0, 32'h0080_0000, 32'hFF80_0000);
        send_word(ACT_COMPUTE, 0, 32'h0, 32'h0);
    endtask

    // Stage count below range, row count zero, and row count clamped to S-1.
    task automatic test_register_clamps();
        configure(1, 15, 127);
        send_word(ACT_COMPUTE, 0, 32'h0, 32'h0);
        configure(0, 0, 0);
        send_word(ACT_COMPUTE, 0, 32'h0, 32'h0);
        configure(3, 15, 2);
        run_compute();
    endtask

    // Writes past the end of each store and the unused action change nothing.
    task automatic test_ignored_words();
        send_word(ACT_MAT_WR, 127, 32'h1234_5678, 32'h0);
        send_word(ACT_MAT_WR, MAT_ENTRIES, 32'h8765_4321, 32'h0);
        send_word(ACT_VEC_WR, MAX_ST, 32'h5555_5555, 32'hAAAA_AAAA);
        send_word(ACT_VEC_WR, 127, 32'hAAAA_AAAA, 32'h5555_5555);
        send_word(ACT_NONE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_COMPUTE, 0, 32'h0, 32'h0);
    endtask

    // Phases of random settings; each phase loads operands in the region that
    // its computes read, with some noise, and runs a few computes.
    task automatic test_random_traffic();
        int phase;
        int stages;
        int rows;
        int n;
        int k;
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            // Phases three to five run with no gaps at all.
            gaps_on = !(phase >= 3 && phase < 6);
            case ($urandom_range(9))
                0:       stages = $urandom_range(1);
                1:       stages = $urandom_range(31, MAX_ST + 1);
                2:       stages = MAX_ST;
                default: stages = $urandom_range(6, 2);
            endcase
            case ($urandom_range(7))
                0:       rows = 0;
                1:       rows = 15;
                default: rows = $urandom_range(5, 1);
            endcase
            configure(stages, rows, ($urandom_range(3) == 0) ? $urandom_range(127) : -1);
            repeat ($urandom_range(3, 1))
            begin
                n = $urandom_range(8);
                for (k = 0; k < n; k++)
                begin
                    case ($urandom_range(19))
                        0: send_word(ACT_NONE, $urandom_range(127), $urandom, $urandom);
                        1: send_word(ACT_MAT_WR, $urandom_range(127, MAT_ENTRIES),
                                     $urandom, $urandom);
                        2: send_word(ACT_VEC_WR, $urandom_range(127, MAX_ST),
                                     $urandom, $urandom);
                        3, 4, 5, 6, 7:
                            send_word(ACT_VEC_WR,
                                      $urandom_range((used_rows() > 0) ? used_rows() - 1
                                                                      : MAX_ST - 1),
                                      pick_q(), pick_q());
                        default: send_word(ACT_MAT_WR, pick_entry(), pick_q(), $urandom);
                    endcase
                end
                run_compute();
            end
            phase++;
        end
    endtask

    // Compare each result word with the oldest expected one.
    task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_rows.size() == 0)
            begin
                $error("row %0d word arrived with no word expected", row);
                fail_count++;
            end
            else
            begin
                head_word = pending_rows.pop_front();
                check_field("row", VAL_W'(head_word.row), VAL_W'(row));
                check_field("out_value", head_word.value, out_value);
                check_field("out_tangent", head_word.tangent, out_tangent);
                check_field("last", VAL_W'(head_word.last), VAL_W'(last));
            end
        end
    end

    // Watchdog: too many cycles with no word moving on any port ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Reset, then the tests in turn, then the final verdict.
    initial
    begin
        start <= 1'b0;
        action <= ACT_MAT_WR;
        index <= '0;
        value <= '0;
        tangent <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_STAGE_COUNT;
        cfg_data <= '0;
        rst_n <= 1'b0;
        stage_reg = STAGE_COUNT_RST;
        rowc_reg = ROW_COUNT_RST;
        deriv_reg = DERIV_ENTRY_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_entry();
        test_rounding();
        test_register_clamps();
        test_ignored_words();
        test_random_traffic();
        wait_idle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
